[rtl/bbpm_pkg.sv]
// ---------------------------------------------------------------------------
// bbpm_pkg
// shared types and codes for the buffer pool manager
// ---------------------------------------------------------------------------
package bbpm_pkg;

  localparam int ID_W  = 6;
  localparam int CNT_W = 7;

  // request type codes
  localparam logic [1:0] REQ_GET      = 2'd0;
  localparam logic [1:0] REQ_RELEASE  = 2'd1;
  localparam logic [1:0] REQ_PREALLOC = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
  localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ID_W-1:0]  buffer_id;
    logic [CNT_W-1:0] target_count;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  granted_id;
    logic [CNT_W-1:0] created_count;
    logic [CNT_W-1:0] free_count;
  } rsp_t;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_GET,
    OP_RELEASE,
    OP_PREALLOC,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  buffer_id;
    logic [CNT_W-1:0] target_count;
  } cmd_t;

endpackage

[rtl/bbpm_ram.sv]
// ---------------------------------------------------------------------------
// bbpm_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module bbpm_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bbpm_fifo.sv]
// ---------------------------------------------------------------------------
// bbpm_fifo
// two-entry queue in flops, used between front, back and result side
// ---------------------------------------------------------------------------
module bbpm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/bbpm_front.sv]
// ---------------------------------------------------------------------------
// bbpm_front
// request intake: decodes the request type and queues it for the back end
// ---------------------------------------------------------------------------
module bbpm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  bbpm_pkg::req_t req,
  output logic           cmd_empty,
  input  logic           cmd_pop,
  output bbpm_pkg::cmd_t cmd
);
  import bbpm_pkg::*;

  cmd_t cmd_in;

  // decode
  always_comb begin
    cmd_in.buffer_id    = req.buffer_id;
    cmd_in.target_count = req.target_count;
    unique case (req.req_type)
      REQ_GET:      cmd_in.op = OP_GET;
      REQ_RELEASE:  cmd_in.op = OP_RELEASE;
      REQ_PREALLOC: cmd_in.op = OP_PREALLOC;
      default:      cmd_in.op = OP_NOP;
    endcase
  end

  bbpm_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

endmodule

[rtl/bbpm_back.sv]
// ---------------------------------------------------------------------------
// bbpm_back
// executes queued requests against the free stack and the pool counters
// ---------------------------------------------------------------------------
module bbpm_back #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bbpm_pkg::CNT_W-1:0]    pool_limit,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  bbpm_pkg::cmd_t                cmd,
  input  logic                          rsp_full,
  output logic                          rsp_push,
  output bbpm_pkg::rsp_t                rsp
);
  import bbpm_pkg::*;

  localparam int ADDR_W    = $clog2(POOL_DEPTH);
  localparam int TOP_W     = $clog2(POOL_DEPTH + 1);
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int DEPTH_SAT = (POOL_DEPTH > CNT_MAX) ? CNT_MAX : POOL_DEPTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GRANT,
    S_FILL
  } state_t;

  state_t           state;
  logic [TOP_W-1:0] top;
  logic [CNT_W-1:0] created;
  logic [CNT_W-1:0] target;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  tgt_clamp;
  logic              stack_full;
  logic              stack_empty;
  logic              start;
  logic              rel_ok;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ID_W-1:0]   ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ID_W-1:0]   ram_rdata;

  assign lim         = (pool_limit > CNT_W'(DEPTH_SAT)) ? CNT_W'(DEPTH_SAT) : pool_limit;
  assign tgt_clamp   = (cmd.target_count > lim) ? lim : cmd.target_count;
  assign stack_full  = (top == TOP_W'(POOL_DEPTH));
  assign stack_empty = (top == '0);
  assign rel_ok      = (CNT_W'(cmd.buffer_id) < created);
  // one request in flight; wait for the last result to land in the queue
  assign start       = (state == S_IDLE) && !cmd_empty && !rsp_full && !rsp_push;
  assign cmd_pop     = start;

  // stack memory control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(top);
    ram_wdata = cmd.buffer_id;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(top - TOP_W'(1));
    if (start) begin
      case (cmd.op)
        OP_GET:     ram_re = !stack_empty;
        OP_RELEASE: ram_we = rel_ok && !stack_full;
        default:    ram_re = 1'b0;
      endcase
    end else if (state == S_FILL) begin
      ram_wdata = created[ID_W-1:0];
      ram_we    = (created < target) && !stack_full;
    end
  end

  bbpm_ram #(
    .WIDTH (ID_W),
    .DEPTH (POOL_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      top      <= '0;
      created  <= '0;
      rsp_push <= 1'b0;
    end else begin
      rsp_push <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rsp.status        <= ST_OK;
            rsp.granted_id    <= '0;
            rsp.created_count <= created;
            rsp.free_count    <= CNT_W'(top);
            unique case (cmd.op)
              OP_GET: begin
                if (!stack_empty) begin
                  top   <= top - TOP_W'(1);
                  state <= S_GRANT;
                end else if (created < lim) begin
                  created           <= created + CNT_W'(1);
                  rsp.granted_id    <= created[ID_W-1:0];
                  rsp.created_count <= created + CNT_W'(1);
                  rsp_push          <= 1'b1;
                end else begin
                  rsp.status <= ST_EXHAUSTED;
                  rsp_push   <= 1'b1;
                end
              end
              OP_RELEASE: begin
                if (!rel_ok) begin
                  rsp.status <= ST_BAD_RELEASE;
                end else if (!stack_full) begin
                  top            <= top + TOP_W'(1);
                  rsp.free_count <= CNT_W'(top + TOP_W'(1));
                end
                rsp_push <= 1'b1;
              end
              OP_PREALLOC: begin
                target <= tgt_clamp;
                state  <= S_FILL;
              end
              OP_NOP: begin
                rsp_push <= 1'b1;
              end
            endcase
          end
        end
        S_GRANT: begin
          // top already points at the slot of the popped entry
          rsp.granted_id <= ram_rdata;
          rsp.free_count <= CNT_W'(top);
          rsp_push       <= 1'b1;
          state          <= S_IDLE;
        end
        S_FILL: begin
          if (created < target) begin
            created <= created + CNT_W'(1);
            if (!stack_full) begin
              top <= top + TOP_W'(1);
            end
          end else begin
            rsp.status        <= ST_OK;
            rsp.granted_id    <= '0;
            rsp.created_count <= created;
            rsp.free_count    <= CNT_W'(top);
            rsp_push          <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/bounded_buffer_pool_manager_unit.sv]
// ---------------------------------------------------------------------------
// bounded_buffer_pool_manager_unit
// buffer identifier allocator with a lifo free stack and a creation limit
// ---------------------------------------------------------------------------
// Requests enter through a queue-style port (push/full) and results leave
// through one (empty/pop), exactly one result per request, in order. The
// front end decodes each request and parks it in a two-entry queue; the back
// end runs one request at a time against the free stack memory and the
// created/free counters, and its results go into a two-entry result queue,
// so intake and result drain stall independently. Release, no-op and a get
// that creates a fresh identifier go from idle straight to their result; a
// get served from the free stack passes through a grant state for the
// registered stack memory read; a preallocate passes through a fill state,
// one identifier per cycle through the single stack write port. The stack
// memory needs no clearing: entries are only read below the stack top,
// where they have been written. The user must write pool_limit through
// cfg_we/cfg_wdata only while no request is pending; the block does not
// enforce this. Effective limit: min of pool_limit, POOL_DEPTH and 127.
// ---------------------------------------------------------------------------
module bounded_buffer_pool_manager_unit #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  // request side
  input  logic                       push,
  output logic                       full,
  input  bbpm_pkg::req_t             req,
  // result side
  output logic                       empty,
  input  logic                       pop,
  output bbpm_pkg::rsp_t             rsp,
  // pool limit register
  input  logic                       cfg_we,
  input  logic [bbpm_pkg::CNT_W-1:0] cfg_wdata
);
  import bbpm_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);

  logic [CNT_W-1:0] pool_limit;
  logic             cmd_empty;
  logic             cmd_pop;
  cmd_t             cmd;
  logic             rsp_full;
  logic             rsp_push;
  rsp_t             rsp_back;

  // pool limit register, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      pool_limit <= cfg_wdata;
    end
  end

  // front end: decode and queue the request
  bbpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // back end: free stack and counters
  bbpm_back #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pool_limit (pool_limit),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .rsp_full   (rsp_full),
    .rsp_push   (rsp_push),
    .rsp        (rsp_back)
  );

  // result queue decouples the back end from the consumer
  bbpm_fifo #(
    .WIDTH ($bits(rsp_t))
  ) u_rsp_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rsp_push),
    .wr_data (rsp_back),
    .full    (rsp_full),
    .rd_en   (pop),
    .rd_data (rsp),
    .empty   (empty)
  );

  // back end never overruns the result queue
  a_rsp_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp_push |-> !rsp_full)
    else $error("result written into a full result queue");

  // back end only takes a request that is there
  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("request taken from an empty request queue");

  // an identifier is handed out only with ok status
  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.status != ST_OK) |-> (rsp.granted_id == '0))
    else $error("identifier granted on a failed request");

  // exhaustion implies the free stack is empty
  a_exhausted_empty: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.status == ST_EXHAUSTED) |-> (rsp.free_count == '0))
    else $error("exhaustion reported with free buffers on the stack");

endmodule
